// ===== rtl/core/sdpcm_pkg.sv =====
// Shared types and constants of the SDPCM frame deframer.
package sdpcm_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 508;
  localparam int unsigned QUEUE_DEPTH_DEF     = 2;
  localparam int unsigned HEADER_MIN          = 12;
  localparam int unsigned CAP_W               = 9;
  localparam int unsigned LEN_W               = 16;
  localparam int unsigned PADDR_W             = 3;
  localparam int unsigned PDATA_W             = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd496;

  localparam int unsigned REG_CAPACITY = 0;

  localparam int unsigned HDR_LEN_LO = 0;
  localparam int unsigned HDR_LEN_HI = 1;
  localparam int unsigned HDR_CMP_LO = 2;
  localparam int unsigned HDR_CMP_HI = 3;
  localparam int unsigned HDR_CHAN   = 5;
  localparam int unsigned HDR_OFFSET = 7;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_HEADER,
    MODE_PAYLOAD
  } mode_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD,
    KIND_DONE,
    KIND_ERROR
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_EMPTY,
    ERR_HEADER,
    ERR_OFFSET
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [7:0]  chan;
    logic        last;
    err_e        code;
  } res_t;

endpackage

// ===== rtl/core/sdpcm_front.sv =====
// Front end: header parse, checks and classification of each received byte.
module sdpcm_front #(
  parameter int unsigned MaxFrameBytes = sdpcm_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      take_i,
  input  logic [7:0]                rx_byte_i,
  input  logic                      frame_start_i,
  input  logic [sdpcm_pkg::CAP_W-1:0] capacity_i,
  output logic                      push_o,
  output sdpcm_pkg::res_t           res_o
);
  import sdpcm_pkg::*;

  localparam int unsigned PW = $clog2(MaxFrameBytes + 1);

  mode_e             mode_q, mode_d, mode_eff;
  logic [PW-1:0]     pos_q, pos_d, pos_eff;
  logic [LEN_W-1:0]  len_q, len_d, cmp_q, cmp_d;
  logic [7:0]        chan_q, chan_d, off_q, off_d;
  logic [LEN_W-1:0]  off_w, span, pos_w, pos_nxt_w;
  err_e              chk_code;
  logic              chk_empty, at_offset, in_payload, is_last;

  assign mode_eff  = frame_start_i ? MODE_HEADER : mode_q;
  assign pos_eff   = frame_start_i ? '0 : pos_q;
  assign at_offset = (pos_eff == PW'(HDR_OFFSET));
  assign pos_w     = LEN_W'(pos_eff);
  assign pos_nxt_w = pos_w + LEN_W'(1);
  assign in_payload = (pos_w >= {8'h00, off_q});
  assign is_last   = (pos_nxt_w >= len_q);

  assign off_w = {8'h00, rx_byte_i};
  assign span  = len_q - off_w;

  always_comb begin
    chk_code = ERR_NONE;
    if (len_q == '0) begin
      chk_code = ERR_EMPTY;
    end else if ((~len_q != cmp_q) || (len_q < LEN_W'(HEADER_MIN)) ||
                 (len_q > LEN_W'(MaxFrameBytes))) begin
      chk_code = ERR_HEADER;
    end else if ((off_w < LEN_W'(HEADER_MIN)) || (off_w > len_q) ||
                 (span > LEN_W'(capacity_i))) begin
      chk_code = ERR_OFFSET;
    end
  end

  assign chk_empty = (off_w == len_q);

  always_comb begin
    mode_d = mode_q;
    if (take_i) begin
      unique case (mode_eff)
        MODE_IDLE: mode_d = MODE_IDLE;
        MODE_HEADER: begin
          if (at_offset) begin
            mode_d = (chk_code == ERR_NONE && !chk_empty) ? MODE_PAYLOAD : MODE_IDLE;
          end else begin
            mode_d = MODE_HEADER;
          end
        end
        MODE_PAYLOAD: mode_d = (in_payload && is_last) ? MODE_IDLE : MODE_PAYLOAD;
        default: mode_d = MODE_IDLE;
      endcase
    end
  end

  always_comb begin
    pos_d  = pos_q;
    len_d  = len_q;
    cmp_d  = cmp_q;
    chan_d = chan_q;
    off_d  = off_q;
    push_o = 1'b0;
    res_o  = '0;
    if (take_i && mode_eff != MODE_IDLE) begin
      pos_d = pos_eff + PW'(1);
      if (mode_eff == MODE_HEADER) begin
        unique case (pos_eff)
          PW'(HDR_LEN_LO): len_d  = {8'h00, rx_byte_i};
          PW'(HDR_LEN_HI): len_d  = {rx_byte_i, len_q[7:0]};
          PW'(HDR_CMP_LO): cmp_d  = {8'h00, rx_byte_i};
          PW'(HDR_CMP_HI): cmp_d  = {rx_byte_i, cmp_q[7:0]};
          PW'(HDR_CHAN):   chan_d = rx_byte_i;
          PW'(HDR_OFFSET): begin
            off_d = rx_byte_i;
            if (chk_code != ERR_NONE) begin
              push_o     = 1'b1;
              res_o.kind = KIND_ERROR;
              res_o.code = chk_code;
            end else if (chk_empty) begin
              push_o     = 1'b1;
              res_o.kind = KIND_DONE;
              res_o.chan = chan_q;
            end
          end
          default: ;
        endcase
      end else if (in_payload) begin
        push_o     = 1'b1;
        res_o.kind = KIND_PAYLOAD;
        res_o.data = rx_byte_i;
        res_o.chan = chan_q;
        res_o.last = is_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pos_q  <= '0;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    cmp_q  <= cmp_d;
    chan_q <= chan_d;
    off_q  <= off_d;
  end

endmodule

// ===== rtl/core/sdpcm_queue.sv =====
// Short result queue between the front end and the output stage.
module sdpcm_queue #(
  parameter int unsigned Depth = sdpcm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sdpcm_pkg::res_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output sdpcm_pkg::res_t data_o,
  output logic            empty_o
);
  import sdpcm_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  res_t          mem [Depth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/sdpcm_back.sv =====
// Output stage: registered result that drains the queue toward the receiver.
module sdpcm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  sdpcm_pkg::res_t data_i,
  output logic            pop_o,
  output logic            valid_o,
  input  logic            ready_i,
  output sdpcm_pkg::res_t res_o
);
  import sdpcm_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign pop_o   = !empty_i && (!valid_q || ready_i);
  assign valid_d = pop_o || (valid_q && !ready_i);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= data_i;
    end
  end

endmodule

// ===== rtl/core/sdpcm_frame_deframer.sv =====
// SDPCM receive deframer top level: stream ports, capacity register, front and back.
//
// Input stream: one frame byte per transfer in s_axis_tdata, s_axis_tuser high on
// the first byte of a frame. A new start abandons any unfinished frame silently.
// Output stream: one result per payload byte, per empty frame, or per failed
// header check. m_axis_tuser is the result kind, m_axis_tlast marks the final
// payload byte, m_axis_tdata carries byte, channel and error code.
// Header checks run on the eighth byte; after an error the rest of the frame
// and any padding produce no transfer.
// Throughput: one byte per cycle sustained while the queue is not full. Each result is
// registered in a queue entry and then in the output register before it appears.
// A two-entry queue and the output register absorb receiver stalls; s_axis_tready
// drops only when the queue is full, with no combinational path from m_axis_tready.
// Configuration: APB register 0 (byte address 0) is payload_capacity, 9 bits; the
// user writes it only while the block is idle, which the block does not enforce.
// Reset: parser idle, queue and output register empty, payload_capacity 496.
module sdpcm_frame_deframer #(
  parameter int unsigned MaxFrameBytes = sdpcm_pkg::MAX_FRAME_BYTES_DEF,
  parameter int unsigned QueueDepth    = sdpcm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
  input  logic                          s_axis_tuser,   // [0] frame_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,   // [7:0] payload_byte,
                                                        // [15:8] channel_id,
                                                        // [17:16] error_code, zero above
  output logic [1:0]                    m_axis_tuser,   // [1:0] kind
  output logic                          m_axis_tlast,   // last_byte
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sdpcm_pkg::PADDR_W-1:0] paddr,
  input  logic [sdpcm_pkg::PDATA_W-1:0] pwdata,
  output logic [sdpcm_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import sdpcm_pkg::*;

  logic [CAP_W-1:0] cap_q, cap_d;
  logic             reg_hit, take, push, full, empty, pop;
  res_t             front_res, head_res, out_res;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == (PADDR_W-2)'(REG_CAPACITY));
  assign cap_d   = (psel && penable && pwrite && reg_hit) ? pwdata[CAP_W-1:0] : cap_q;
  assign prdata  = reg_hit ? PDATA_W'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  assign s_axis_tready = !full;
  assign take          = s_axis_tvalid && !full;

  sdpcm_front #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .rx_byte_i    (s_axis_tdata),
    .frame_start_i(s_axis_tuser),
    .capacity_i   (cap_q),
    .push_o       (push),
    .res_o        (front_res)
  );

  sdpcm_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_res),
    .full_o (full),
    .pop_i  (pop),
    .data_o (head_res),
    .empty_o(empty)
  );

  sdpcm_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(empty),
    .data_i (head_res),
    .pop_o  (pop),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .res_o  (out_res)
  );

  assign m_axis_tdata = {6'b0, out_res.code, out_res.chan, out_res.data};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule
